>>> rtl/checksummed_frame_receiver_macros.svh
// Assertion macros used by the receiver's top level.
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CFR_ASSERT_IMPL(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("cfr check failed");

// next-cycle implication
`define CFR_ASSERT_NEXT(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("cfr check failed");

`endif

>>> rtl/cfr_pkg.sv
// Types and constants of the checksummed frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package cfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int MAX_PAYLOAD_LIM = 64;

	localparam int DATA_W   = 8;
	localparam int LEN_W    = 6;
	localparam int STATUS_W = 2;
	localparam int SKIP_W   = 9;
	localparam int JOB_CNT_W  = $clog2(MAX_PAYLOAD_LIM + 1);
	localparam int MEM_ADDR_W = $clog2(MAX_PAYLOAD_LIM);
	localparam int Q_DEPTH  = 2;

	localparam logic [DATA_W-1:0] START_RESET = 8'd170;
	localparam logic [LEN_W-1:0]  LEN_RESET   = 6'd16;

	// configuration register indexes
	localparam logic CFG_START = 1'b0;
	localparam logic CFG_LEN   = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CSUM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LEN  = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_DATA,
		PH_CHECK,
		PH_SKIP
	} phase_t;

	typedef enum logic {
		BK_IDLE,
		BK_PLAY
	} bk_state_t;

	// one finished frame handed from front to back
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [JOB_CNT_W-1:0] cnt;
	} job_t;

	typedef struct packed {
		logic                  we;
		logic [MEM_ADDR_W-1:0] addr;
		logic [DATA_W-1:0]     data;
	} mem_wr_t;

endpackage
`default_nettype wire

>>> rtl/cfr_if.sv
// Request channels of the receiver: received bytes in, results out.
`timescale 1ns / 1ps
`default_nettype none
interface cfr_rx_if;
	logic                      valid;
	logic                      ready;
	logic [cfr_pkg::DATA_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_tx_if;
	logic                        valid;
	logic                        ready;
	logic [cfr_pkg::DATA_W-1:0]   payload_byte;
	logic                        last;
	logic [cfr_pkg::STATUS_W-1:0] status;

	modport source (output valid, output payload_byte, output last, output status,
		input ready);
	modport sink   (input valid, input payload_byte, input last, input status,
		output ready);
endinterface
`default_nettype wire

>>> rtl/checksummed_frame_receiver.sv
// Top level of the checksummed frame receiver.
//
// rx: one received byte per request. Bytes are hunted for the start value;
// the next byte is the length, then the payload, then an XOR checksum seeded
// with the length byte. tx: results. A good frame gives one request per
// payload byte, status OK, last set on the final one. A bad checksum gives a
// single CSUM status, a wrong length a single LEN status on the byte where
// the checksum would have been; both carry last set and a zero payload.
// cfg: write enable, index (0 start value, 1 expected length) and data.
// A status result passes through the job queue and the output register; a
// good frame plays out from the payload store's read port after its job is
// popped, one payload byte per cycle while tx is ready.
// Bytes are taken one per cycle; the payload bytes of a following frame wait
// while the previous frame still plays out, and the two-entry job queue
// stalls rx when it is full. A stalled tx holds its result and the front
// keeps parsing until the queue fills. Reset clears all control state and
// loads start value 170 and expected length 16; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "checksummed_frame_receiver_macros.svh"
module checksummed_frame_receiver #(
	parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [cfr_pkg::DATA_W-1:0] cfg_data,
	cfr_rx_if.sink                          rx,
	cfr_tx_if.source                        tx
);
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic             play_done;
	cfr_pkg::job_t    job;
	cfr_pkg::job_t    q_head;
	cfr_pkg::mem_wr_t mem_wr;

	cfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx),
		.q_full    (q_full),
		.play_done (play_done),
		.q_push    (q_push),
		.job       (job),
		.mem_wr    (mem_wr)
	);

	cfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (job),
		.pop    (q_pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	cfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.play_done (play_done),
		.tx        (tx)
	);

	`CFR_ASSERT_IMPL(a_no_push_full, q_push, !q_full || q_pop)
	`CFR_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_empty)
	`CFR_ASSERT_IMPL(a_status_last, tx.valid && tx.status != cfr_pkg::ST_OK, tx.last && tx.payload_byte == '0)
	`CFR_ASSERT_NEXT(a_done_ends_frame, play_done && tx.ready, tx.valid && tx.last)

endmodule
`default_nettype wire

>>> rtl/cfr_queue.sv
// Short job queue between the frame parser and the playback engine.
`timescale 1ns / 1ps
`default_nettype none
module cfr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cfr_pkg::job_t din,
	input  wire logic          pop,
	output cfr_pkg::job_t      dout,
	output logic               full,
	output logic               empty
);
	localparam int PW = (cfr_pkg::Q_DEPTH > 1) ? $clog2(cfr_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(cfr_pkg::Q_DEPTH + 1);

	cfr_pkg::job_t  entry_q [cfr_pkg::Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(cfr_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(cfr_pkg::Q_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(cfr_pkg::Q_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			if (push && !pop)
				count_q <= CW'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= CW'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= din;
	end

endmodule
`default_nettype wire

>>> rtl/cfr_front.sv
// Frame parser: hunts, checks length, stores payload, computes XOR, posts jobs.
`timescale 1ns / 1ps
`default_nettype none
module cfr_front #(
	parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [cfr_pkg::DATA_W-1:0] cfg_data,
	cfr_rx_if.sink                  rx,
	input  wire logic               q_full,
	input  wire logic               play_done,
	output logic                    q_push,
	output cfr_pkg::job_t           job,
	output cfr_pkg::mem_wr_t        mem_wr
);
	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	cfr_pkg::phase_t                phase_q, phase_d;
	logic [cfr_pkg::DATA_W-1:0]     start_q;
	logic [cfr_pkg::LEN_W-1:0]      explen_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  len_q;
	logic [cfr_pkg::DATA_W-1:0]     xor_q;
	logic [cfr_pkg::SKIP_W-1:0]     skip_q;
	logic                           ok_pend_q;
	logic                           acc;
	logic                           len_ok;
	logic                           data_end;
	logic                           csum_ok;
	logic [cfr_pkg::DATA_W-1:0]     b;

	assign b = rx.rx_byte;
	// payload writes wait while the store still holds a frame being played out
	assign rx.ready = !q_full && !(phase_q == cfr_pkg::PH_DATA && ok_pend_q);
	assign acc = rx.valid && rx.ready;

	assign len_ok = (explen_q != '0) && ({1'b0, explen_q} <= 7'(MAX_PAYLOAD))
		&& (b == {2'b00, explen_q});
	assign data_end = (CW'(count_q + 1'b1) == len_q);
	assign csum_ok  = (b == xor_q);

	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			case (phase_q)
				cfr_pkg::PH_HUNT: if (b == start_q) phase_d = cfr_pkg::PH_LEN;
				cfr_pkg::PH_LEN: phase_d = len_ok ? cfr_pkg::PH_DATA : cfr_pkg::PH_SKIP;
				cfr_pkg::PH_DATA: if (data_end) phase_d = cfr_pkg::PH_CHECK;
				cfr_pkg::PH_CHECK: phase_d = cfr_pkg::PH_HUNT;
				cfr_pkg::PH_SKIP: if (skip_q == 9'd1) phase_d = cfr_pkg::PH_HUNT;
				default: phase_d = cfr_pkg::PH_HUNT;
			endcase
		end
	end

	always_comb begin
		q_push = 1'b0;
		job    = '0;
		mem_wr = '0;
		if (acc) begin
			case (phase_q)
				cfr_pkg::PH_DATA: begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = cfr_pkg::MEM_ADDR_W'(count_q);
					mem_wr.data = b;
				end
				cfr_pkg::PH_CHECK: begin
					q_push     = 1'b1;
					job.status = csum_ok ? cfr_pkg::ST_OK : cfr_pkg::ST_CSUM;
					job.cnt    = csum_ok ? cfr_pkg::JOB_CNT_W'(len_q) : '0;
				end
				cfr_pkg::PH_SKIP: begin
					if (skip_q == 9'd1) begin
						q_push     = 1'b1;
						job.status = cfr_pkg::ST_LEN;
					end
				end
				default: q_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cfr_pkg::PH_HUNT;
			start_q   <= cfr_pkg::START_RESET;
			explen_q  <= cfr_pkg::LEN_RESET;
			ok_pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (cfg_we) begin
				case (cfg_index)
					cfr_pkg::CFG_START: start_q  <= cfg_data;
					cfr_pkg::CFG_LEN:   explen_q <= cfg_data[cfr_pkg::LEN_W-1:0];
					default: start_q <= start_q;
				endcase
			end
			if (q_push && job.status == cfr_pkg::ST_OK)
				ok_pend_q <= 1'b1;
			else if (play_done)
				ok_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			case (phase_q)
				cfr_pkg::PH_LEN: begin
					xor_q   <= b;
					count_q <= '0;
					len_q   <= CW'(b);
					skip_q  <= cfr_pkg::SKIP_W'({1'b0, b} + 9'd1);
				end
				cfr_pkg::PH_DATA: begin
					count_q <= CW'(count_q + 1'b1);
					xor_q   <= xor_q ^ b;
				end
				cfr_pkg::PH_SKIP: skip_q <= cfr_pkg::SKIP_W'(skip_q - 9'd1);
				default: xor_q <= xor_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/cfr_back.sv
// Playback engine: payload store, job execution and the result output register.
`timescale 1ns / 1ps
`default_nettype none
module cfr_back #(
	parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfr_pkg::mem_wr_t mem_wr,
	input  wire logic             q_empty,
	input  wire cfr_pkg::job_t    q_head,
	output logic                  q_pop,
	output logic                  play_done,
	cfr_tx_if.source              tx
);
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	logic [cfr_pkg::DATA_W-1:0]   mem [MAX_PAYLOAD];
	logic [cfr_pkg::DATA_W-1:0]   rd_q;
	cfr_pkg::bk_state_t           state_q, state_d;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                idx_q;
	logic                         out_valid_q;
	logic                         out_last_q;
	logic [cfr_pkg::STATUS_W-1:0] out_status_q;
	logic                         out_free;
	logic                         last_idx;
	logic                         load_stat;
	logic                         load_play;

	assign out_free = !out_valid_q || tx.ready;
	assign last_idx = ((CW'(idx_q) + CW'(1)) == cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfr_pkg::BK_IDLE:
				if (q_pop && q_head.status == cfr_pkg::ST_OK) state_d = cfr_pkg::BK_PLAY;
			cfr_pkg::BK_PLAY:
				if (load_play && last_idx) state_d = cfr_pkg::BK_IDLE;
			default: state_d = cfr_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		load_stat = 1'b0;
		load_play = 1'b0;
		play_done = 1'b0;
		case (state_q)
			cfr_pkg::BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop     = 1'b1;
					load_stat = (q_head.status != cfr_pkg::ST_OK);
				end
			end
			cfr_pkg::BK_PLAY: begin
				if (out_free) begin
					load_play = 1'b1;
					play_done = last_idx;
				end
			end
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfr_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_stat || load_play)
				out_valid_q <= 1'b1;
			else if (tx.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cnt_q <= CW'(q_head.cnt);
			idx_q <= '0;
		end else if (load_play) begin
			idx_q <= AW'(idx_q + 1'b1);
		end
		if (load_stat) begin
			out_last_q   <= 1'b1;
			out_status_q <= q_head.status;
		end else if (load_play) begin
			out_last_q   <= last_idx;
			out_status_q <= cfr_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr.we)
			mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
	end

	// registered read doubles as the output payload register
	always_ff @(posedge clk) begin
		if (load_play)
			rd_q <= mem[idx_q];
	end

	assign tx.valid        = out_valid_q;
	assign tx.last         = out_last_q;
	assign tx.status       = out_status_q;
	assign tx.payload_byte = (out_status_q == cfr_pkg::ST_OK) ? rd_q : '0;

endmodule
`default_nettype wire
